// ----- sv/pswm_pkg.sv -----
package pswm_pkg;

  // field and datapath widths
  localparam int DATA_W    = 16;
  localparam int ERR_W     = 17;
  localparam int GAIN_W    = 16;
  localparam int CFG_IDX_W = 3;

  // shared multiplier operand and product widths
  localparam int MUL_A_W = 32;
  localparam int MUL_B_W = 17;
  localparam int PROD_W  = MUL_A_W + MUL_B_W;

  // magnitude of speed times curvature, below 2^31
  localparam int QUO_W = 31;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GAIN_P      = 3'd0,
    REG_GAIN_I      = 3'd1,
    REG_GAIN_D      = 3'd2,
    REG_BASE_SPEED  = 3'd3,
    REG_MAX_CURV    = 3'd4,
    REG_MAX_WHEEL   = 3'd5,
    REG_TRACK_WIDTH = 3'd6
  } cfg_reg_t;

endpackage

// ----- sv/pid_steering_wheel_mixer_top.sv -----
// the sequencer takes one request at a time: in_stall stays high until the result
// is written to the output register, which waits while the output is stalled;
// steps in order: three pid products and their sums, accumulate, clamp,
// speed times curvature, sign split, two reciprocal passes for CURV_SCALE,
// the track width product, halving and the wheel mix
// reset (rst, synchronous, active high) clears the error history and the
// curvature accumulator and loads the register defaults
module pid_steering_wheel_mixer_top #(
  parameter int CURV_SCALE = 10000
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_write,
  input  logic [pswm_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [pswm_pkg::DATA_W-1:0]          cfg_data,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic signed [pswm_pkg::DATA_W-1:0]   deviation,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic signed [15:0]                   left_target,
  output logic signed [15:0]                   right_target,
  output logic signed [pswm_pkg::ERR_W-1:0]    error_out,
  output logic signed [15:0]                   curvature_out
);
  import pswm_pkg::*;

  localparam int D1_W   = ERR_W + 1;
  localparam int D2_W   = ERR_W + 2;
  localparam int S_W    = 38;
  localparam int SPD_W  = 17;
  localparam int HP_W   = 42;
  localparam int HALF_W = HP_W - 1;
  localparam int MIX_W  = HALF_W + 2;

  typedef enum logic [3:0] {
    S_IDLE, S_MUL_P, S_MUL_I, S_MUL_D, S_PID_SUM, S_ACC, S_CLAMP,
    S_MUL_R, S_DIV_GO, S_DIV_LO, S_DIV_HI, S_DIV_SUM, S_MUL_H, S_HALF, S_MIX
  } state_t;

  function automatic logic signed [15:0] clamp_sym(
    input logic signed [MIX_W-1:0] v,
    input logic        [14:0]      lim
  );
    logic signed [MIX_W-1:0] l;
    logic signed [MIX_W-1:0] nl;
    l  = $signed(MIX_W'(lim));
    nl = -l;
    if (v > l) begin
      return l[15:0];
    end else if (v < nl) begin
      return nl[15:0];
    end
    return v[15:0];
  endfunction

  state_t state;

  // configuration registers
  logic signed [GAIN_W-1:0] gain_p, gain_i, gain_d;
  logic signed [DATA_W-1:0] base_speed;
  logic [14:0]              max_curv, max_wheel;
  logic [9:0]               track_width;

  // loop state
  logic signed [ERR_W-1:0]  last_error, prev_error;
  logic signed [15:0]       curvature_acc;

  // per-request working registers
  logic signed [ERR_W-1:0]  err;
  logic signed [D1_W-1:0]   d1;
  logic signed [D2_W-1:0]   d2;
  logic signed [S_W-1:0]    s;
  logic signed [15:0]       acc;
  logic signed [SPD_W-1:0]  speed;
  logic signed [15:0]       curv;
  logic                     rate_neg;
  logic [QUO_W-1:0]         div_n;
  logic signed [MUL_A_W-1:0] rate;
  logic signed [HALF_W-1:0] half;

  // datapath wires
  logic signed [ERR_W-1:0]   e_in;
  logic signed [D1_W-1:0]    d1_in;
  logic signed [D2_W-1:0]    d2_in;
  logic signed [MUL_A_W-1:0] op_a;
  logic signed [MUL_B_W-1:0] op_b;
  logic signed [PROD_W-1:0]  prod;
  logic signed [S_W-1:0]     prod_s;
  logic [15:0]               delta_lo;
  logic signed [SPD_W:0]     spd2;
  logic signed [SPD_W-1:0]   speed_v;
  logic [MUL_A_W-1:0]        prod_abs;
  logic                      lo_load;
  logic signed [MUL_B_W-1:0] recip_lo;
  logic signed [MUL_B_W-1:0] recip_hi;
  logic [QUO_W-1:0]          quot;
  logic signed [HP_W-1:0]    hp;
  logic signed [MIX_W-1:0]   left_v, right_v;
  logic                      accept;

  assign in_stall = (state != S_IDLE);
  assign accept   = in_valid && !in_stall;

  // error history terms for an incoming request
  always_comb begin
    e_in  = -$signed({deviation[DATA_W-1], deviation});
    d1_in = D1_W'(e_in) - D1_W'(last_error);
    d2_in = D2_W'(e_in) - (D2_W'(last_error) <<< 1) + D2_W'(prev_error);
  end

  // operand select for the shared multiplier
  always_comb begin
    op_a = '0;
    op_b = '0;
    case (state)
      S_MUL_P: begin
        op_a = MUL_A_W'(d1);
        op_b = MUL_B_W'(gain_p);
      end
      S_MUL_I: begin
        op_a = MUL_A_W'(err);
        op_b = MUL_B_W'(gain_i);
      end
      S_MUL_D: begin
        op_a = MUL_A_W'(d2);
        op_b = MUL_B_W'(gain_d);
      end
      S_MUL_R: begin
        op_a = MUL_A_W'(speed);
        op_b = MUL_B_W'(curv);
      end
      S_DIV_LO: begin
        op_a = MUL_A_W'(div_n);
        op_b = recip_lo;
      end
      S_DIV_HI: begin
        op_a = MUL_A_W'(div_n);
        op_b = recip_hi;
      end
      S_MUL_H: begin
        op_a = rate;
        op_b = $signed(MUL_B_W'(track_width));
      end
      default: begin
        op_a = '0;
        op_b = '0;
      end
    endcase
  end

  pswm_mul u_mul (
    .clk  (clk),
    .op_a (op_a),
    .op_b (op_b),
    .prod (prod)
  );

  // derived terms from registered values
  always_comb begin
    prod_s   = S_W'(prod);
    // pid sum divided by 2^16 toward zero, low 16 bits only
    delta_lo = s[31:16] + {15'b0, s[S_W-1] & (|s[15:0])};
    spd2     = ((SPD_W + 1)'(base_speed) <<< 1) - (SPD_W + 1)'(acc);
    speed_v  = spd2[SPD_W:1] + {{(SPD_W - 1){1'b0}}, spd2[SPD_W] & spd2[0]};
    prod_abs = prod[PROD_W-1] ? (-prod[MUL_A_W-1:0]) : prod[MUL_A_W-1:0];
    lo_load  = (state == S_DIV_HI);
    hp       = prod[HP_W-1:0];
    left_v   = MIX_W'(speed) - MIX_W'(half);
    right_v  = MIX_W'(speed) + MIX_W'(half);
  end

  pswm_div #(
    .CURV_SCALE (CURV_SCALE)
  ) u_div (
    .clk      (clk),
    .lo_load  (lo_load),
    .prod     (prod),
    .recip_lo (recip_lo),
    .recip_hi (recip_hi),
    .quotient (quot)
  );

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      gain_p      <= '0;
      gain_i      <= '0;
      gain_d      <= '0;
      base_speed  <= '0;
      max_curv    <= 15'd1000;
      max_wheel   <= 15'd1000;
      track_width <= 10'd20;
    end else if (cfg_write) begin
      case (cfg_reg_t'(cfg_index))
        REG_GAIN_P:      gain_p      <= $signed(cfg_data);
        REG_GAIN_I:      gain_i      <= $signed(cfg_data);
        REG_GAIN_D:      gain_d      <= $signed(cfg_data);
        REG_BASE_SPEED:  base_speed  <= $signed(cfg_data);
        REG_MAX_CURV:    max_curv    <= cfg_data[14:0];
        REG_MAX_WHEEL:   max_wheel   <= cfg_data[14:0];
        REG_TRACK_WIDTH: track_width <= cfg_data[9:0];
        default: ;
      endcase
    end
  end

  // sequencer, loop state and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      out_valid     <= 1'b0;
      last_error    <= '0;
      prev_error    <= '0;
      curvature_acc <= '0;
    end else begin
      if (out_valid && !out_stall && state != S_MIX) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            err        <= e_in;
            d1         <= d1_in;
            d2         <= d2_in;
            prev_error <= last_error;
            last_error <= e_in;
            state      <= S_MUL_P;
          end
        end
        S_MUL_P: state <= S_MUL_I;
        S_MUL_I: begin
          s     <= prod_s;
          state <= S_MUL_D;
        end
        S_MUL_D: begin
          s     <= s + prod_s;
          state <= S_PID_SUM;
        end
        S_PID_SUM: begin
          s     <= s + prod_s;
          state <= S_ACC;
        end
        S_ACC: begin
          acc   <= $signed(curvature_acc + $signed(delta_lo));
          state <= S_CLAMP;
        end
        S_CLAMP: begin
          speed         <= speed_v;
          curv          <= clamp_sym(MIX_W'(acc), max_curv);
          curvature_acc <= clamp_sym(MIX_W'(acc), max_curv);
          state         <= S_MUL_R;
        end
        S_MUL_R: state <= S_DIV_GO;
        S_DIV_GO: begin
          rate_neg <= prod[PROD_W-1];
          div_n    <= prod_abs[QUO_W-1:0];
          state    <= S_DIV_LO;
        end
        S_DIV_LO: state <= S_DIV_HI;
        S_DIV_HI: state <= S_DIV_SUM;
        S_DIV_SUM: begin
          rate  <= rate_neg ? -$signed({1'b0, quot}) : $signed({1'b0, quot});
          state <= S_MUL_H;
        end
        S_MUL_H: state <= S_HALF;
        S_HALF: begin
          // halve toward zero
          half  <= hp[HP_W-1:1] + {{(HALF_W - 1){1'b0}}, hp[HP_W-1] & hp[0]};
          state <= S_MIX;
        end
        S_MIX: begin
          if (!out_valid || !out_stall) begin
            left_target   <= clamp_sym(left_v, max_wheel);
            right_target  <= clamp_sym(right_v, max_wheel);
            error_out     <= err;
            curvature_out <= curv;
            out_valid     <= 1'b1;
            state         <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ----- sv/pswm_mul.sv -----
module pswm_mul (
  input  logic                               clk,
  input  logic signed [pswm_pkg::MUL_A_W-1:0] op_a,
  input  logic signed [pswm_pkg::MUL_B_W-1:0] op_b,
  output logic signed [pswm_pkg::PROD_W-1:0]  prod
);
  import pswm_pkg::*;

  // signed multiply, product registered
  always_ff @(posedge clk) begin
    prod <= op_a * op_b;
  end

endmodule

// ----- sv/pswm_div.sv -----
module pswm_div #(
  parameter int CURV_SCALE = 10000
) (
  input  logic                                clk,
  input  logic                                lo_load,
  input  logic signed [pswm_pkg::PROD_W-1:0]  prod,
  output logic signed [pswm_pkg::MUL_B_W-1:0] recip_lo,
  output logic signed [pswm_pkg::MUL_B_W-1:0] recip_hi,
  output logic        [pswm_pkg::QUO_W-1:0]   quotient
);
  import pswm_pkg::*;

  // reciprocal floor(2^(QUO_W+l) / d) + 1 with 2^l >= d, exact for
  // every dividend below 2^QUO_W
  localparam int          DIV_L    = $clog2(CURV_SCALE);
  localparam int          RSHIFT   = QUO_W + DIV_L;
  localparam logic [31:0] RECIP    =
    32'(((longint'(1) << RSHIFT) / longint'(CURV_SCALE)) + 1);
  localparam int          SUM_W    = QUO_W + MUL_B_W;
  localparam int          HI_SHIFT = RSHIFT - 16;

  logic [31:0]      lo_part;
  logic [SUM_W-1:0] sum;
  logic [SUM_W-1:0] quo_full;

  // reciprocal halves as non-negative multiplier operands
  assign recip_lo = $signed({1'b0, RECIP[15:0]});
  assign recip_hi = $signed({1'b0, RECIP[31:16]});

  // low half product, only bit 16 and up are kept
  always_ff @(posedge clk) begin
    if (lo_load) begin
      lo_part <= prod[SUM_W-1:16];
    end
  end

  // high half product plus the carried low part, then scale down
  always_comb begin
    sum      = prod[SUM_W-1:0] + SUM_W'(lo_part);
    quo_full = sum >> HI_SHIFT;
    quotient = quo_full[QUO_W-1:0];
  end

endmodule

// ----- tb/pid_steering_wheel_mixer_top_test.sv -----
module pid_steering_wheel_mixer_top_test;
  import pswm_pkg::*;

  localparam int CLK_PERIOD     = 8;
  localparam int RESET_CYCLES   = 6;
  localparam int LATENCY        = 14;
  localparam int DRAIN_LIMIT    = 5000;
  localparam int HOLD_CYCLES    = 600;
  localparam int TIMEOUT_CYCLES = 1000000;
  localparam int BATCHES        = 20;
  localparam int BATCH_ITEMS    = 100;
  localparam longint CURV_DIV   = 10000;

  // index outside the register list, writes to it are dropped
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

  typedef struct {
    logic signed [15:0]      lft;
    logic signed [15:0]      rgt;
    logic signed [ERR_W-1:0] err;
    logic signed [15:0]      curv;
  } wheel_cmd_t;

  logic                          clk = 1'b0;
  logic                          rst = 1'b1;
  logic                          cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0]          cfg_index = '0;
  logic [DATA_W-1:0]             cfg_data = '0;
  logic                          in_valid = 1'b0;
  logic                          in_stall;
  logic signed [DATA_W-1:0]      deviation = '0;
  logic                          out_valid;
  logic                          out_stall = 1'b0;
  logic signed [15:0]            left_target;
  logic signed [15:0]            right_target;
  logic signed [ERR_W-1:0]       error_out;
  logic signed [15:0]            curvature_out;

  // mirror of the register file
  logic signed [15:0] kp, ki, kd, base_m;
  logic [14:0]        curv_lim, wheel_lim;
  logic [9:0]         track_m;

  // mirror of the controller history
  logic signed [ERR_W-1:0] err_last, err_prev;
  logic signed [15:0]      curv_acc;

  wheel_cmd_t pending_cmds[$];

  int  send_idle_pct = 0;
  int  recv_idle_pct = 0;
  logic hold_off = 1'b0;
  int  fail_count = 0;
  int  mismatch_count = 0;
  int  samples_sent = 0;
  int  results_checked = 0;
  int  settings_count = 0;
  logic signed [15:0] walk_dev = '0;

  pid_steering_wheel_mixer_top DUT (
    .clk           (clk),
    .rst           (rst),
    .cfg_write     (cfg_write),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .deviation     (deviation),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .left_target   (left_target),
    .right_target  (right_target),
    .error_out     (error_out),
    .curvature_out (curvature_out)
  );

  // clock
  initial begin
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  // watchdog
  initial begin
    #(longint'(TIMEOUT_CYCLES) * CLK_PERIOD);
    $display("Some tests failed");
    $finish;
  end

  function automatic longint clamp_sym(longint v, longint lim);
    if (v > lim) return lim;
    if (v < -lim) return -lim;
    return v;
  endfunction

  // register and history values after reset
  function automatic void reset_mirror();
    kp = '0;
    ki = '0;
    kd = '0;
    base_m = '0;
    curv_lim = 15'd1000;
    wheel_lim = 15'd1000;
    track_m = 10'd20;
    err_last = '0;
    err_prev = '0;
    curv_acc = '0;
  endfunction

  // incremental pid, curvature update and wheel split for one sample
  function automatic wheel_cmd_t predict_wheels(logic signed [DATA_W-1:0] dev);
    longint e, s, delta, acc, speed, curv, rate, half;
    logic signed [15:0] acc16;
    wheel_cmd_t r;
    e = -longint'(dev);
    s = longint'(kp) * (e - longint'(err_last)) + longint'(ki) * e
      + longint'(kd) * (e - 2 * longint'(err_last) + longint'(err_prev));
    delta = s / 65536;
    err_prev = err_last;
    err_last = ERR_W'(e);
    acc16 = 16'(longint'(curv_acc) + delta);
    acc = acc16;
    speed = (2 * longint'(base_m) - acc) / 2;
    curv = clamp_sym(acc, longint'(curv_lim));
    curv_acc = 16'(curv);
    rate = (speed * curv) / CURV_DIV;
    half = (rate * longint'(track_m)) / 2;
    r.lft = 16'(clamp_sym(speed - half, longint'(wheel_lim)));
    r.rgt = 16'(clamp_sym(speed + half, longint'(wheel_lim)));
    r.err = ERR_W'(e);
    r.curv = 16'(curv);
    return r;
  endfunction

  // compare one delivered result against the oldest prediction
  function automatic void check_wheels();
    wheel_cmd_t want;
    if (pending_cmds.size() == 0) begin
      fail_count++;
      mismatch_count++;
      if (mismatch_count <= 10)
        $display("unexpected result: left %0d right %0d error %0d curvature %0d",
                 left_target, right_target, error_out, curvature_out);
      return;
    end
    want = pending_cmds.pop_front();
    results_checked++;
    if (left_target !== want.lft || right_target !== want.rgt ||
        error_out !== want.err || curvature_out !== want.curv) begin
      fail_count++;
      mismatch_count++;
      if (mismatch_count <= 10)
        $display("mismatch on result %0d: left %0d/%0d right %0d/%0d error %0d/%0d curv %0d/%0d",
                 results_checked, want.lft, left_target, want.rgt, right_target,
                 want.err, error_out, want.curv, curvature_out);
    end
  endfunction

  // result side: check accepted results and choose the next stall
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) check_wheels();
    if (rst) out_stall <= 1'b0;
    else if (hold_off) out_stall <= 1'b1;
    else out_stall <= ($urandom_range(99) < recv_idle_pct);
  end

  // one register write; cfg_write is left high for the caller to drop
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DATA_W-1:0] value);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    case (idx)
      REG_GAIN_P:      kp = value;
      REG_GAIN_I:      ki = value;
      REG_GAIN_D:      kd = value;
      REG_BASE_SPEED:  base_m = value;
      REG_MAX_CURV:    curv_lim = value[14:0];
      REG_MAX_WHEEL:   wheel_lim = value[14:0];
      REG_TRACK_WIDTH: track_m = value[9:0];
      default: ;
    endcase
  endtask

  task automatic set_config(input int gp, input int gi, input int gd, input int bs,
                            input int mc, input int mw, input int tw);
    write_reg(REG_GAIN_P, DATA_W'(gp));
    write_reg(REG_GAIN_I, DATA_W'(gi));
    write_reg(REG_GAIN_D, DATA_W'(gd));
    write_reg(REG_BASE_SPEED, DATA_W'(bs));
    write_reg(REG_MAX_CURV, DATA_W'(mc));
    write_reg(REG_MAX_WHEEL, DATA_W'(mw));
    write_reg(REG_TRACK_WIDTH, DATA_W'(tw));
    cfg_write <= 1'b0;
    settings_count++;
  endtask

  // offer one sample, with random idle gaps, until the block takes it
  task automatic send_sample(input logic signed [DATA_W-1:0] dev);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    deviation <= dev;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_cmds.push_back(predict_wheels(dev));
    samples_sent++;
  endtask

  // wait for every outstanding result, then let the pipeline settle
  task automatic drain_results();
    int guard;
    guard = 0;
    in_valid <= 1'b0;
    while (pending_cmds.size() != 0 && guard < DRAIN_LIMIT) begin
      @(posedge clk);
      guard++;
    end
    if (pending_cmds.size() != 0) begin
      fail_count += pending_cmds.size();
      $display("%0d results never arrived", pending_cmds.size());
      pending_cmds.delete();
    end
    repeat (LATENCY + 8) @(posedge clk);
  endtask

  // mostly a slow drifting line, with full-range and extreme samples mixed in
  function automatic logic signed [DATA_W-1:0] next_deviation();
    int pick, w;
    pick = $urandom_range(99);
    if (pick < 30) return DATA_W'($urandom);
    if (pick < 36) return $urandom_range(1) ? 16'sh7FFF : 16'sh8000;
    w = int'(walk_dev) + int'($urandom_range(1024)) - 512;
    if (w > 32767) w = 32767;
    if (w < -32768) w = -32768;
    walk_dev = 16'(w);
    return walk_dev;
  endfunction

  task automatic random_config(input bit wide);
    int gp, gi, gd, bs, mc, mw, tw;
    if (wide) begin
      gp = $urandom_range(65535) - 32768;
      gi = $urandom_range(65535) - 32768;
      gd = $urandom_range(65535) - 32768;
      bs = $urandom_range(65534) - 32767;
      mc = $urandom_range(32767);
      mw = $urandom_range(32767);
      tw = $urandom_range(1023);
    end else begin
      gp = $urandom_range(2048) - 1024;
      gi = $urandom_range(2048) - 1024;
      gd = $urandom_range(2048) - 1024;
      bs = $urandom_range(8000) - 4000;
      mc = $urandom_range(4000);
      mw = $urandom_range(6000);
      tw = $urandom_range(64);
    end
    if ($urandom_range(9) == 0) mc = 0;
    if ($urandom_range(9) == 0) mw = 0;
    set_config(gp, gi, gd, bs, mc, mw, tw);
  endtask

  // defaults straight after reset, then integral gain and base speed with the default limits
  task automatic test_reset_defaults();
    send_sample(16'sh7FFF);
    drain_results();
    write_reg(REG_GAIN_I, 16'sd4096);
    write_reg(REG_BASE_SPEED, 16'sd3000);
    cfg_write <= 1'b0;
    send_sample(16'sh8000);
    send_sample(16'sh8000);
    drain_results();
  endtask

  // extreme gains, speeds, limits and deviations
  task automatic test_field_extremes();
    set_config(-32768, -32768, -32768, -32767, 32767, 32767, 1023);
    send_sample(16'sh7FFF);
    send_sample(16'sh8000);
    send_sample(16'sh0000);
    send_sample(16'sh0001);
    send_sample(16'shFFFF);
    drain_results();
    set_config(32767, 32767, 32767, 32767, 32767, 32767, 1023);
    send_sample(16'sh8000);
    send_sample(16'sh7FFF);
    send_sample(16'sh8000);
    drain_results();
  endtask

  // pure integral drive so the accumulator wraps past both ends
  task automatic test_accumulator_wrap();
    set_config(0, 32767, 0, 1000, 32767, 32767, 1);
    repeat (4) send_sample(16'sh8000);
    repeat (4) send_sample(16'sh7FFF);
    drain_results();
  endtask

  // zero curvature limit and zero wheel limit, one at a time
  task automatic test_zero_limits();
    set_config(256, 256, 256, 5000, 0, 32767, 20);
    send_sample(16'sh4000);
    send_sample(-16'sh2000);
    drain_results();
    set_config(256, 256, 256, 5000, 500, 0, 20);
    send_sample(16'sh4000);
    send_sample(-16'sh2000);
    drain_results();
  endtask

  // a write outside the register list must leave every setting alone
  task automatic test_unused_index();
    write_reg(REG_UNUSED, 16'hFFFF);
    cfg_write <= 1'b0;
    send_sample(16'sh1234);
    send_sample(-16'sh0800);
    drain_results();
  endtask

  task automatic test_random_batch(input int n, input bit wide);
    random_config(wide);
    repeat (n) send_sample(next_deviation());
    drain_results();
  endtask

  // long output hold-off while requests keep coming, filling the block
  task automatic test_backpressure();
    set_config(512, 128, 64, 2000, 3000, 4000, 30);
    fork
      begin
        hold_off <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_off <= 1'b0;
      end
    join_none
    repeat (12) send_sample(next_deviation());
    drain_results();
  endtask

  initial begin
    reset_mirror();
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_idle_pct = 33;
    recv_idle_pct = 65;
    test_reset_defaults();
    test_field_extremes();
    test_accumulator_wrap();
    test_zero_limits();
    test_unused_index();

    for (int b = 0; b < BATCHES; b++) begin
      if (b == BATCHES / 3) begin
        send_idle_pct = 65;
        recv_idle_pct = 33;
      end else if (b == 2 * BATCHES / 3) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      test_random_batch(BATCH_ITEMS, (b % 4) == 3);
    end

    test_backpressure();

    $display("Ran %0d steering samples under %0d register settings, %0d results checked",
             samples_sent, settings_count, results_checked);
    $display("Included reset defaults, clamp extremes, accumulator wrap and a %0d-cycle hold-off",
             HOLD_CYCLES);
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
